@@ sv/assert_macros.svh @@
// assertion macros for the rtl files that check themselves; only the top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold on the edge after the antecedent
`define PRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/prc_pkg.sv @@
// shared constants, request codes and controller command type for the philox generator
package prc_pkg;

  localparam int WORD_W       = 32;
  localparam int CTR_W        = 4 * WORD_W;
  localparam int HALF_W       = 2 * WORD_W;
  localparam int REQ_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int ROUND_COUNT_DEF = 10;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GENERATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SKIP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MUL_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MUL_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEYL_A   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WEYL_B   = 3'd7;

  // register reset values
  localparam logic [WORD_W-1:0] MUL_A_RST  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B_RST  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] WEYL_A_RST = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] WEYL_B_RST = 32'hBB67AE85;

  typedef struct packed {
    logic load_block;
    logic do_round;
    logic apply_skip;
    logic apply_restart;
    logic emit;
  } prc_cmd_t;

endpackage

@@ sv/prc_ctrl.sv @@
// sequencer for request intake, the round loop and the result register handshake
module prc_ctrl
  import prc_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [REQ_W-1:0] req_type,
  output logic             req_ready,
  output logic             res_valid,
  input  logic             res_ready,
  output prc_cmd_t         cmd
);

  localparam int RCW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RCW-1:0] LAST_ROUND = RCW'(ROUND_COUNT - 1);

  typedef enum logic [1:0] {
    IDLE,
    ROUND,
    EMIT
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [RCW-1:0] rnd;
  logic [RCW-1:0] rnd_next;
  logic           res_valid_next;
  logic           take;

  assign req_ready = (state == IDLE);
  assign take      = req_valid && req_ready;

  always_comb begin
    cmd               = '0;
    cmd.load_block    = take && (req_type == REQ_GENERATE);
    cmd.apply_skip    = take && (req_type == REQ_SKIP);
    cmd.apply_restart = take && (req_type == REQ_RESTART);
    cmd.do_round      = (state == ROUND);
    cmd.emit          = (state == EMIT) && (!res_valid || res_ready);
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    case (state)
      IDLE: begin
        if (cmd.load_block) begin
          state_next = ROUND;
          rnd_next   = '0;
        end
      end
      ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = EMIT;
        end else begin
          rnd_next = rnd + 1'b1;
        end
      end
      EMIT: begin
        if (cmd.emit) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rnd       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

@@ sv/prc_datapath.sv @@
// config registers, 128-bit counter, shared philox round unit and result register
module prc_datapath
  import prc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  prc_cmd_t              cmd,
  input  logic [HALF_W-1:0]     skip_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CTR_W-1:0]      res_data
);

  logic [WORD_W-1:0] key0;
  logic [WORD_W-1:0] key1;
  logic [HALF_W-1:0] start_lo;
  logic [HALF_W-1:0] start_hi;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] weyl_a;
  logic [WORD_W-1:0] weyl_b;

  logic [CTR_W-1:0]  ctr;
  logic [CTR_W-1:0]  ctr_next;
  logic [CTR_W-1:0]  addend;

  logic [WORD_W-1:0] w0, w1, w2, w3;
  logic [WORD_W-1:0] k0, k1;
  logic [HALF_W-1:0] prod_p;
  logic [HALF_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0     <= '0;
      key1     <= '0;
      start_lo <= '0;
      start_hi <= '0;
      mul_a    <= MUL_A_RST;
      mul_b    <= MUL_B_RST;
      weyl_a   <= WEYL_A_RST;
      weyl_b   <= WEYL_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0:     key0     <= cfg_data[WORD_W-1:0];
        CFG_KEY1:     key1     <= cfg_data[WORD_W-1:0];
        CFG_START_LO: start_lo <= cfg_data;
        CFG_START_HI: start_hi <= cfg_data;
        CFG_MUL_A:    mul_a    <= cfg_data[WORD_W-1:0];
        CFG_MUL_B:    mul_b    <= cfg_data[WORD_W-1:0];
        CFG_WEYL_A:   weyl_a   <= cfg_data[WORD_W-1:0];
        CFG_WEYL_B:   weyl_b   <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // one adder serves both the post-generate increment and the skip
  assign addend   = cmd.emit ? CTR_W'(1) : {{HALF_W{1'b0}}, skip_count};
  assign ctr_next = ctr + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.apply_restart) begin
      ctr <= {start_hi, start_lo};
    end else if (cmd.apply_skip || cmd.emit) begin
      ctr <= ctr_next;
    end
  end

  assign prod_p = HALF_W'(mul_a) * HALF_W'(w0);
  assign prod_q = HALF_W'(mul_b) * HALF_W'(w2);

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      w0 <= ctr[WORD_W-1:0];
      w1 <= ctr[2*WORD_W-1:WORD_W];
      w2 <= ctr[3*WORD_W-1:2*WORD_W];
      w3 <= ctr[4*WORD_W-1:3*WORD_W];
      k0 <= key0;
      k1 <= key1;
    end else if (cmd.do_round) begin
      w0 <= prod_q[HALF_W-1:WORD_W] ^ w1 ^ k0;
      w1 <= prod_q[WORD_W-1:0];
      w2 <= prod_p[HALF_W-1:WORD_W] ^ w3 ^ k1;
      w3 <= prod_p[WORD_W-1:0];
      k0 <= k0 + weyl_a;
      k1 <= k1 + weyl_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_data <= {w3, w2, w1, w0};
    end
  end

endmodule

@@ sv/philox_counter_rng_top.sv @@
// generate: the block is loaded when the request is accepted, runs ROUND_COUNT rounds, then the result is loaded
// one philox round per cycle on the shared round unit; input reopens the cycle after the load
// so a new generate is taken only after its result is loaded, later while a result waits unread
// skip and restart requests keep the input open and return nothing
// reset clears the counter, restores register defaults and empties the result register
`include "assert_macros.svh"

module philox_counter_rng_top
  import prc_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [HALF_W-1:0]     s_axis_tdata,   // skip_count[63:0]
  input  logic [REQ_W-1:0]      s_axis_tuser,   // req_type[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CTR_W-1:0]      m_axis_tdata,   // word3 in the top bits down to word0 in the bottom bits
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  prc_cmd_t cmd;
  logic     gen_take;
  logic     op_take;

  prc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_type  (s_axis_tuser),
    .req_ready (s_axis_tready),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .cmd       (cmd)
  );

  prc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .skip_count (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_data   (m_axis_tdata)
  );

  assign gen_take = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_GENERATE);
  assign op_take  = s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_GENERATE);

  // a generate request keeps the input closed while its rounds run
  `PRC_ASSERT_NEXT(a_gen_busy, gen_take, !s_axis_tready, "input open right after a generate")
  // skip and restart keep the input open
  `PRC_ASSERT_NEXT(a_ctr_op_fast, op_take, s_axis_tready, "input closed after a counter-only request")
  // a new result only appears at the end of a generate
  `PRC_ASSERT(a_res_from_gen, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result while idle")

endmodule
